// ===== rtl/hsv_chroma_keyer_assert.svh =====
// Assertion helpers shared by the keyer RTL.
`ifndef HSV_CHROMA_KEYER_ASSERT_SVH
`define HSV_CHROMA_KEYER_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define HCK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HCK_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/hck_pkg.sv =====
package hck_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned HueW     = 13;
  localparam int unsigned SpanW    = 12;
  localparam int unsigned PctW     = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned SatW     = 15;

  localparam int unsigned DivNW  = 20;
  localparam int unsigned DivDW  = 12;
  localparam int unsigned DivQW  = 10;
  localparam int unsigned DivShW = DivDW + DivQW - 1;

  localparam int unsigned NumLane   = 4;
  localparam int unsigned LaneBlue  = 0;
  localparam int unsigned LaneGreen = 1;
  localparam int unsigned LaneRed   = 2;
  localparam int unsigned LaneAlpha = 3;

  localparam int unsigned StgIn    = 0;
  localparam int unsigned StgSat   = 1;
  localparam int unsigned StgHdiv0 = 2;
  localparam int unsigned StgHue   = StgHdiv0 + DivQW;
  localparam int unsigned StgWin   = StgHue + 1;
  localparam int unsigned StgMode  = StgWin + 1;
  localparam int unsigned StgProd  = StgMode + 1;
  localparam int unsigned StgRdiv0 = StgProd + 1;
  localparam int unsigned StgOut   = StgRdiv0 + DivQW;
  localparam int unsigned NumStg   = StgOut + 1;

  localparam int unsigned HueScale  = 960;
  localparam int unsigned HueSector = 1920;
  localparam int unsigned HueFull   = 5760;
  localparam int unsigned SatScale  = 100;
  localparam int unsigned ChanMax   = 255;

  localparam logic [HueW-1:0]  HueLowRst    = 13'd2560;
  localparam logic [HueW-1:0]  HueHighRst   = 13'd3360;
  localparam logic [HueW-1:0]  HueCentreRst = 13'd2960;
  localparam logic [SpanW-1:0] RadiusRst    = 12'd240;
  localparam logic [SpanW-1:0] RampRst      = 12'd160;
  localparam logic [ChanW-1:0] MinBrightRst = 8'd100;
  localparam logic [PctW-1:0]  MinSatRst    = 7'd8;

  typedef enum logic [CfgIdxW-1:0] {
    RegHueLow      = 3'd0,
    RegHueHigh     = 3'd1,
    RegHueCentre   = 3'd2,
    RegSolidRadius = 3'd3,
    RegRampWidth   = 3'd4,
    RegMinBright   = 3'd5,
    RegMinSat      = 3'd6
  } hck_reg_e;

  typedef enum logic [1:0] {
    MaxRed,
    MaxGreen,
    MaxBlue
  } hck_max_e;

  typedef enum logic [1:0] {
    ModePass,
    ModeSolid,
    ModeRamp
  } hck_mode_e;

  typedef struct packed {
    logic [ChanW-1:0] pixel_blue;
    logic [ChanW-1:0] pixel_green;
    logic [ChanW-1:0] pixel_red;
    logic [ChanW-1:0] pixel_alpha;
  } hck_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_alpha;
    logic             was_keyed;
  } hck_out_t;

  typedef struct packed {
    hck_in_t          px;
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] dlt;
    logic [ChanW-1:0] nab;
    logic             neg;
    hck_max_e         sel;
    logic             bypass;
    logic [HueW-1:0]  hue;
    logic [HueW-1:0]  hdist;
    hck_mode_e        mode;
    logic [SpanW-1:0] tval;
  } hck_side_t;

endpackage

// ===== rtl/hck_div.sv =====
module hck_div (
  input  logic                        clk_i,
  input  logic [hck_pkg::DivQW-1:0]   en_i,
  input  logic [hck_pkg::DivNW-1:0]   dividend_i,
  input  logic [hck_pkg::DivDW-1:0]   divisor_i,
  output logic [hck_pkg::DivQW-1:0]   quotient_o
);

  localparam int unsigned NW  = hck_pkg::DivNW;
  localparam int unsigned DW  = hck_pkg::DivDW;
  localparam int unsigned QW  = hck_pkg::DivQW;
  localparam int unsigned ShW = hck_pkg::DivShW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] dsr_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int unsigned Bit = QW - 1 - s;

    logic [NW-1:0]  rem_in;
    logic [DW-1:0]  dsr_in;
    logic [QW-1:0]  quo_in;
    logic [ShW-1:0] rem_ext;
    logic [ShW-1:0] dsr_sh;
    logic           ge;
    logic [NW-1:0]  rem_d;
    logic [QW-1:0]  quo_d;

    if (s == 0) begin : g_first
      assign rem_in = dividend_i;
      assign dsr_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign dsr_in = dsr_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      rem_ext    = ShW'(rem_in);
      dsr_sh     = ShW'(dsr_in) << Bit;
      ge         = (rem_ext >= dsr_sh);
      rem_d      = ge ? NW'(rem_ext - dsr_sh) : rem_in;
      quo_d      = quo_in;
      quo_d[Bit] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d;
        dsr_q[s] <= dsr_in;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quotient_o = quo_q[QW-1];

endmodule

// ===== rtl/hsv_chroma_keyer.sv =====
// HSV hue-range chroma keyer for a BGRA pixel stream.
// Pixels enter on in_valid_i/in_ready_o/in_data_i and leave on
// out_valid_o/out_ready_i/out_data_o; a transaction completes on a rising
// edge with valid and ready both high. The seven key registers are written
// through cfg_we_i, cfg_idx_i and cfg_data_i; the user must write them only
// while no pixel is in flight, as the block itself does not enforce this.
// The datapath is 27 register stages: channel max and min, saturation test,
// a ten-stage restoring divider for the hue, window and distance stages,
// the alpha products, and four ten-stage dividers for the alpha ramp.
// One pixel is accepted per cycle while in_ready_o is high; every stage
// holds a valid bit and a stage takes a new pixel whenever it or any stage
// after it is empty or the receiver is ready. When the receiver stalls, the
// output register holds its transaction and the pipeline keeps filling its
// empty stages; in_ready_o falls only when all 27 stages hold pixels.
// Reset empties the pipeline and loads the default key settings.
`include "hsv_chroma_keyer_assert.svh"

module hsv_chroma_keyer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hck_pkg::hck_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hck_pkg::hck_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [hck_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hck_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned ChanW  = hck_pkg::ChanW;
  localparam int unsigned HueW   = hck_pkg::HueW;
  localparam int unsigned SpanW  = hck_pkg::SpanW;
  localparam int unsigned PctW   = hck_pkg::PctW;
  localparam int unsigned SatW   = hck_pkg::SatW;
  localparam int unsigned DivNW  = hck_pkg::DivNW;
  localparam int unsigned DivDW  = hck_pkg::DivDW;
  localparam int unsigned DivQW  = hck_pkg::DivQW;
  localparam int unsigned NumStg = hck_pkg::NumStg;
  localparam int unsigned NumSd  = hck_pkg::StgOut;
  localparam int unsigned NumLn  = hck_pkg::NumLane;

  logic [HueW-1:0]  low_q, high_q, centre_q;
  logic [SpanW-1:0] radius_q, ramp_q;
  logic [ChanW-1:0] minb_q;
  logic [PctW-1:0]  pct_q;

  logic [NumStg-1:0] v_q, v_d, en;
  hck_pkg::hck_side_t s_q [NumSd];
  hck_pkg::hck_side_t s_d [NumSd];

  logic [DivNW-1:0] hdvd_d, hdvd_q;
  logic [DivQW-1:0] hq;
  logic [ChanW-1:0] lane_val [NumLn];
  logic [DivNW-1:0] prod_d [NumLn];
  logic [DivNW-1:0] prod_q [NumLn];
  logic [DivQW-1:0] rq [NumLn];

  hck_pkg::hck_out_t out_d, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= hck_pkg::HueLowRst;
      high_q   <= hck_pkg::HueHighRst;
      centre_q <= hck_pkg::HueCentreRst;
      radius_q <= hck_pkg::RadiusRst;
      ramp_q   <= hck_pkg::RampRst;
      minb_q   <= hck_pkg::MinBrightRst;
      pct_q    <= hck_pkg::MinSatRst;
    end else if (cfg_we_i) begin
      case (hck_pkg::hck_reg_e'(cfg_idx_i))
        hck_pkg::RegHueLow:      low_q    <= cfg_data_i[HueW-1:0];
        hck_pkg::RegHueHigh:     high_q   <= cfg_data_i[HueW-1:0];
        hck_pkg::RegHueCentre:   centre_q <= cfg_data_i[HueW-1:0];
        hck_pkg::RegSolidRadius: radius_q <= cfg_data_i[SpanW-1:0];
        hck_pkg::RegRampWidth:   ramp_q   <= cfg_data_i[SpanW-1:0];
        hck_pkg::RegMinBright:   minb_q   <= cfg_data_i[ChanW-1:0];
        hck_pkg::RegMinSat:      pct_q    <= cfg_data_i[PctW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    en[NumStg-1] = !v_q[NumStg-1] || out_ready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NumStg; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    logic [ChanW-1:0] pb, pg, pr, mx, mn;
    logic [SatW-1:0]  sat_lhs, sat_rhs;
    logic [HueW:0]    hue_base, hue_sum;
    logic [HueW-1:0]  hue, hdist, ramp_end;
    logic             in_win;

    for (int k = 1; k < NumSd; k++) begin
      s_d[k] = s_q[k-1];
    end

    pb = in_data_i.pixel_blue;
    pg = in_data_i.pixel_green;
    pr = in_data_i.pixel_red;
    mx = (pr > pg) ? ((pr > pb) ? pr : pb) : ((pg > pb) ? pg : pb);
    mn = (pr < pg) ? ((pr < pb) ? pr : pb) : ((pg < pb) ? pg : pb);
    s_d[hck_pkg::StgIn]        = '0;
    s_d[hck_pkg::StgIn].px     = in_data_i;
    s_d[hck_pkg::StgIn].mx     = mx;
    s_d[hck_pkg::StgIn].dlt    = mx - mn;
    s_d[hck_pkg::StgIn].mode   = hck_pkg::ModePass;
    if (pr == mx) begin
      s_d[hck_pkg::StgIn].sel = hck_pkg::MaxRed;
      s_d[hck_pkg::StgIn].neg = (pg < pb);
      s_d[hck_pkg::StgIn].nab = (pg < pb) ? (pb - pg) : (pg - pb);
    end else if (pg == mx) begin
      s_d[hck_pkg::StgIn].sel = hck_pkg::MaxGreen;
      s_d[hck_pkg::StgIn].neg = (pb < pr);
      s_d[hck_pkg::StgIn].nab = (pb < pr) ? (pr - pb) : (pb - pr);
    end else begin
      s_d[hck_pkg::StgIn].sel = hck_pkg::MaxBlue;
      s_d[hck_pkg::StgIn].neg = (pr < pg);
      s_d[hck_pkg::StgIn].nab = (pr < pg) ? (pg - pr) : (pr - pg);
    end

    sat_lhs = SatW'(s_q[hck_pkg::StgIn].dlt) * SatW'(hck_pkg::SatScale);
    sat_rhs = SatW'(pct_q) * SatW'(s_q[hck_pkg::StgIn].mx);
    s_d[hck_pkg::StgSat].bypass = (s_q[hck_pkg::StgIn].dlt == '0) ||
                                  (s_q[hck_pkg::StgIn].mx == '0) ||
                                  (sat_lhs < sat_rhs);

    case (s_q[hck_pkg::StgHue-1].sel)
      hck_pkg::MaxRed:   hue_base = '0;
      hck_pkg::MaxGreen: hue_base = (HueW+1)'(hck_pkg::HueSector);
      hck_pkg::MaxBlue:  hue_base = (HueW+1)'(2 * hck_pkg::HueSector);
      default:           hue_base = '0;
    endcase
    hue_sum = s_q[hck_pkg::StgHue-1].neg ? (hue_base - (HueW+1)'(hq))
                                         : (hue_base + (HueW+1)'(hq));
    hue = hue_sum[HueW] ? HueW'(hue_sum + (HueW+1)'(hck_pkg::HueFull))
                        : hue_sum[HueW-1:0];
    s_d[hck_pkg::StgHue].hue = hue;

    in_win = (s_q[hck_pkg::StgWin-1].hue >= low_q) &&
             (s_q[hck_pkg::StgWin-1].hue <= high_q) &&
             (s_q[hck_pkg::StgWin-1].mx > minb_q);
    hdist = (s_q[hck_pkg::StgWin-1].hue >= centre_q) ?
            (s_q[hck_pkg::StgWin-1].hue - centre_q) :
            (centre_q - s_q[hck_pkg::StgWin-1].hue);
    s_d[hck_pkg::StgWin].bypass = s_q[hck_pkg::StgWin-1].bypass || !in_win;
    s_d[hck_pkg::StgWin].hdist  = hdist;

    ramp_end = HueW'(radius_q) + HueW'(ramp_q);
    if (s_q[hck_pkg::StgMode-1].bypass) begin
      s_d[hck_pkg::StgMode].mode = hck_pkg::ModePass;
    end else if (s_q[hck_pkg::StgMode-1].hdist <= HueW'(radius_q)) begin
      s_d[hck_pkg::StgMode].mode = hck_pkg::ModeSolid;
    end else if (s_q[hck_pkg::StgMode-1].hdist >= ramp_end) begin
      s_d[hck_pkg::StgMode].mode = hck_pkg::ModePass;
    end else begin
      s_d[hck_pkg::StgMode].mode = hck_pkg::ModeRamp;
    end
    s_d[hck_pkg::StgMode].tval = SpanW'(s_q[hck_pkg::StgMode-1].hdist - HueW'(radius_q));
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumSd; k++) begin
      if (en[k]) begin
        s_q[k] <= s_d[k];
      end
    end
  end

  assign hdvd_d = DivNW'(s_q[hck_pkg::StgIn].nab) * DivNW'(hck_pkg::HueScale);

  always_ff @(posedge clk_i) begin
    if (en[hck_pkg::StgSat]) begin
      hdvd_q <= hdvd_d;
    end
  end

  hck_div u_hue_div (
    .clk_i      (clk_i),
    .en_i       (en[hck_pkg::StgHdiv0 +: DivQW]),
    .dividend_i (hdvd_q),
    .divisor_i  (DivDW'(s_q[hck_pkg::StgSat].dlt)),
    .quotient_o (hq)
  );

  always_comb begin
    lane_val[hck_pkg::LaneBlue]  = s_q[hck_pkg::StgProd-1].px.pixel_blue;
    lane_val[hck_pkg::LaneGreen] = s_q[hck_pkg::StgProd-1].px.pixel_green;
    lane_val[hck_pkg::LaneRed]   = s_q[hck_pkg::StgProd-1].px.pixel_red;
    lane_val[hck_pkg::LaneAlpha] = ChanW'(hck_pkg::ChanMax);
    for (int j = 0; j < NumLn; j++) begin
      prod_d[j] = DivNW'(lane_val[j]) * DivNW'(s_q[hck_pkg::StgProd-1].tval);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[hck_pkg::StgProd]) begin
      for (int j = 0; j < NumLn; j++) begin
        prod_q[j] <= prod_d[j];
      end
    end
  end

  for (genvar j = 0; j < NumLn; j++) begin : g_ramp
    hck_div u_ramp_div (
      .clk_i      (clk_i),
      .en_i       (en[hck_pkg::StgRdiv0 +: DivQW]),
      .dividend_i (prod_q[j]),
      .divisor_i  (ramp_q),
      .quotient_o (rq[j])
    );
  end

  always_comb begin
    case (s_q[NumSd-1].mode)
      hck_pkg::ModeSolid: begin
        out_d           = '0;
        out_d.was_keyed = 1'b1;
      end
      hck_pkg::ModeRamp: begin
        out_d.out_blue  = rq[hck_pkg::LaneBlue][ChanW-1:0];
        out_d.out_green = rq[hck_pkg::LaneGreen][ChanW-1:0];
        out_d.out_red   = rq[hck_pkg::LaneRed][ChanW-1:0];
        out_d.out_alpha = rq[hck_pkg::LaneAlpha][ChanW-1:0];
        out_d.was_keyed = 1'b1;
      end
      default: begin
        out_d.out_blue  = s_q[NumSd-1].px.pixel_blue;
        out_d.out_green = s_q[NumSd-1].px.pixel_green;
        out_d.out_red   = s_q[NumSd-1].px.pixel_red;
        out_d.out_alpha = s_q[NumSd-1].px.pixel_alpha;
        out_d.was_keyed = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[hck_pkg::StgOut]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[hck_pkg::StgOut];
  assign out_data_o  = out_q;

  `HCK_ASSERT_RST(a_reset_empty, !rst_ni |-> (v_q == '0), "Pipeline holds a transaction in reset.")
  `HCK_ASSERT(a_stall_full, !in_ready_o |-> (&v_q), "Input stalled with a free pipeline stage.")
  `HCK_ASSERT(a_hue_quot, (v_q[hck_pkg::StgHue-1] && !s_q[hck_pkg::StgHue-1].bypass) |-> (hq <= DivQW'(hck_pkg::HueScale)), "Hue quotient out of range.")
  `HCK_ASSERT(a_ramp_quot, (v_q[NumSd-1] && (s_q[NumSd-1].mode == hck_pkg::ModeRamp)) |-> (rq[hck_pkg::LaneAlpha] < DivQW'(hck_pkg::ChanMax)), "Ramp alpha reached full scale.")
  `HCK_ASSERT(a_premult, (out_valid_o && out_data_o.was_keyed) |-> ((out_data_o.out_red <= out_data_o.out_alpha) && (out_data_o.out_green <= out_data_o.out_alpha) && (out_data_o.out_blue <= out_data_o.out_alpha)), "Premultiplied channel exceeds alpha.")

endmodule

// ===== test/tb_hsv_chroma_keyer.sv =====
`timescale 1ns / 1ps

module tb_hsv_chroma_keyer;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 32;
  localparam logic [hck_pkg::CfgIdxW-1:0] RegNone = 3'd7;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b1;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  hck_pkg::hck_in_t             in_data_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  hck_pkg::hck_out_t            out_data_o;
  logic                         cfg_we_i = 1'b0;
  logic [hck_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [hck_pkg::CfgDataW-1:0] cfg_data_i = '0;

  logic [hck_pkg::HueW-1:0]  key_low = hck_pkg::HueLowRst;
  logic [hck_pkg::HueW-1:0]  key_high = hck_pkg::HueHighRst;
  logic [hck_pkg::HueW-1:0]  key_centre = hck_pkg::HueCentreRst;
  logic [hck_pkg::SpanW-1:0] key_radius = hck_pkg::RadiusRst;
  logic [hck_pkg::SpanW-1:0] key_ramp = hck_pkg::RampRst;
  logic [hck_pkg::ChanW-1:0] key_bright = hck_pkg::MinBrightRst;
  logic [hck_pkg::PctW-1:0]  key_sat_pct = hck_pkg::MinSatRst;

  hck_pkg::hck_out_t expected_px[$];
  hck_pkg::hck_out_t want;
  int       mismatches = 0;
  int       quiet_cycles = 0;
  bit       calm = 1'b0;

  hsv_chroma_keyer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic hck_pkg::hck_out_t key_pixel(hck_pkg::hck_in_t p);
    hck_pkg::hck_out_t o;
    int b, g, r, hi, lo, dl, n, base, q, hue, hdist, t;
    b = p.pixel_blue;
    g = p.pixel_green;
    r = p.pixel_red;
    o.out_blue = p.pixel_blue;
    o.out_green = p.pixel_green;
    o.out_red = p.pixel_red;
    o.out_alpha = p.pixel_alpha;
    o.was_keyed = 1'b0;
    hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    dl = hi - lo;
    if (dl == 0 || hi == 0) return o;
    if (dl * hck_pkg::SatScale < int'(key_sat_pct) * hi) return o;
    if (hi == r) begin
      n = g - b;
      base = 0;
    end else if (hi == g) begin
      n = b - r;
      base = hck_pkg::HueSector;
    end else begin
      n = r - g;
      base = 2 * hck_pkg::HueSector;
    end
    q = ((n < 0) ? -n : n) * hck_pkg::HueScale / dl;
    if (n < 0) q = -q;
    hue = base + q;
    if (hue < 0) hue += hck_pkg::HueFull;
    if (hue < int'(key_low) || hue > int'(key_high) || hi <= int'(key_bright)) return o;
    hdist = hue - int'(key_centre);
    if (hdist < 0) hdist = -hdist;
    if (hdist <= int'(key_radius)) begin
      o = '0;
      o.was_keyed = 1'b1;
      return o;
    end
    if (hdist >= int'(key_radius) + int'(key_ramp)) return o;
    t = hdist - int'(key_radius);
    o.out_blue = 8'(b * t / int'(key_ramp));
    o.out_green = 8'(g * t / int'(key_ramp));
    o.out_red = 8'(r * t / int'(key_ramp));
    o.out_alpha = 8'(hck_pkg::ChanMax * t / int'(key_ramp));
    o.was_keyed = 1'b1;
    return o;
  endfunction

  function automatic int idle_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic hck_pkg::hck_in_t px(int b, int g, int r, int a);
    hck_pkg::hck_in_t p;
    p.pixel_blue = 8'(b);
    p.pixel_green = 8'(g);
    p.pixel_red = 8'(r);
    p.pixel_alpha = 8'(a);
    return p;
  endfunction

  // Mostly saturated colors of every hue, with some greys and fully random pixels.
  function automatic hck_pkg::hck_in_t rand_pixel();
    int sel, hi, lo, mid;
    sel = $urandom_range(0, 9);
    if (sel < 2) return hck_pkg::hck_in_t'($urandom);
    if (sel == 2) begin
      mid = $urandom_range(0, 255);
      return px(mid, mid, mid, $urandom_range(0, 255));
    end
    hi = $urandom_range(60, 255);
    lo = $urandom_range(0, hi);
    mid = $urandom_range(lo, hi);
    case ($urandom_range(0, 5))
      0: return px(hi, mid, lo, $urandom_range(0, 255));
      1: return px(hi, lo, mid, $urandom_range(0, 255));
      2: return px(mid, hi, lo, $urandom_range(0, 255));
      3: return px(lo, hi, mid, $urandom_range(0, 255));
      4: return px(mid, lo, hi, $urandom_range(0, 255));
      default: return px(lo, mid, hi, $urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(hck_pkg::hck_in_t p);
    int gap;
    gap = idle_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    expected_px.push_back(key_pixel(p));
  endtask

  task automatic send_burst(int count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  task automatic drain(int margin);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (margin) @(posedge clk_i);
  endtask

  task automatic write_key(logic [hck_pkg::CfgIdxW-1:0] idx,
                           logic [hck_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      hck_pkg::RegHueLow:      key_low = val[hck_pkg::HueW-1:0];
      hck_pkg::RegHueHigh:     key_high = val[hck_pkg::HueW-1:0];
      hck_pkg::RegHueCentre:   key_centre = val[hck_pkg::HueW-1:0];
      hck_pkg::RegSolidRadius: key_radius = val[hck_pkg::SpanW-1:0];
      hck_pkg::RegRampWidth:   key_ramp = val[hck_pkg::SpanW-1:0];
      hck_pkg::RegMinBright:   key_bright = val[hck_pkg::ChanW-1:0];
      hck_pkg::RegMinSat:      key_sat_pct = val[hck_pkg::PctW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_keys(int low, int high, int centre, int radius, int ramp, int bright,
                          int pct);
    drain(DrainCycles);
    write_key(hck_pkg::RegHueLow, hck_pkg::CfgDataW'(low));
    write_key(hck_pkg::RegHueHigh, hck_pkg::CfgDataW'(high));
    write_key(hck_pkg::RegHueCentre, hck_pkg::CfgDataW'(centre));
    write_key(hck_pkg::RegSolidRadius, hck_pkg::CfgDataW'(radius));
    write_key(hck_pkg::RegRampWidth, hck_pkg::CfgDataW'(ramp));
    write_key(hck_pkg::RegMinBright, hck_pkg::CfgDataW'(bright));
    write_key(hck_pkg::RegMinSat, hck_pkg::CfgDataW'(pct));
  endtask

  task automatic test_reset_defaults();
    send_pixel(px(0, 0, 0, 0));
    send_pixel(px(255, 255, 255, 255));
    send_pixel(px(77, 77, 77, 200));
    send_pixel(px(100, 105, 100, 9));
    send_pixel(px(0, 0, 255, 128));
    send_pixel(px(100, 0, 255, 1));
    send_pixel(px(255, 0, 0, 255));
    send_pixel(px(255, 255, 0, 255));
    send_pixel(px(0, 255, 255, 77));
    send_pixel(px(255, 0, 255, 30));
    send_pixel(px(100, 100, 0, 50));
    send_pixel(px(101, 101, 0, 50));
    send_pixel(px(197, 255, 0, 255));
    send_pixel(px(170, 255, 0, 90));
    send_pixel(px(171, 255, 0, 0));
    send_pixel(px(255, 128, 0, 255));
    send_pixel(px(200, 200, 184, 66));
    send_pixel(px(200, 200, 185, 66));
    send_pixel(px(255, 0, 0, 0));
  endtask

  task automatic test_register_limits();
    set_keys(0, hck_pkg::HueFull - 1, 0, 0, 2 * hck_pkg::HueSector * 3 / 4, 0, 0);
    send_burst(60);
    set_keys(0, 13'h1FFF, hck_pkg::HueFull - 1, hck_pkg::HueFull / 2, hck_pkg::HueFull / 2,
             0, hck_pkg::SatScale);
    send_burst(60);
    // A ramp width with only bit 12 set is masked to zero.
    set_keys(0, hck_pkg::HueFull - 1, hck_pkg::HueFull / 2, 500, 13'h1000, 254, 0);
    send_burst(60);
    set_keys(4000, 1000, 2500, 100, 300, 0, 0);
    send_burst(60);
    set_keys(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    write_key(RegNone, 13'h0000);
    send_burst(60);
  endtask

  task automatic test_random_keys();
    int centre, low, high;
    for (int ph = 0; ph < 8; ph++) begin
      centre = $urandom_range(0, hck_pkg::HueFull - 1);
      low = centre - int'($urandom_range(0, 1500));
      high = centre + int'($urandom_range(0, 1500));
      if (low < 0) low = 0;
      if (high > hck_pkg::HueFull - 1) high = hck_pkg::HueFull - 1;
      calm = 1'b0;
      set_keys(low, high, centre, $urandom_range(0, 300), $urandom_range(1, 900),
               $urandom_range(0, 150), $urandom_range(0, 40));
      calm = (ph == 2 || ph == 5);
      send_burst(100);
      drain(0);
      send_burst(100);
    end
    calm = 1'b0;
  endtask

  task automatic check_field(string what, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  initial begin : drive_out_ready
    int n;
    forever begin
      @(negedge clk_i);
      n = idle_gap();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_px.size() == 0) begin
        $display("%0t ns: unexpected transaction, got %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = expected_px.pop_front();
        check_field("out_blue", want.out_blue, out_data_o.out_blue);
        check_field("out_green", want.out_green, out_data_o.out_green);
        check_field("out_red", want.out_red, out_data_o.out_red);
        check_field("out_alpha", want.out_alpha, out_data_o.out_alpha);
        check_field("was_keyed", want.was_keyed, out_data_o.was_keyed);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("hsv_chroma_keyer verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_register_limits();
    test_random_keys();
    drain(DrainCycles);
    if (mismatches == 0) begin
      $display("hsv_chroma_keyer verification clean");
    end else begin
      $display("hsv_chroma_keyer verification failed");
    end
    $finish;
  end

endmodule
